FILE: design/bts_pkg.sv
// Shared types, constants and helpers of the bilinear texture sampler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bts_pkg;

   // Field and register widths.
   localparam int CFG_W        = 7;
   localparam int CHANNEL_W    = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int ADDR_W       = 14;
   localparam int VALUE_W      = 24;
   localparam int COORD_W      = 17;
   localparam int FRAC_W       = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Reset values of the registers.
   localparam logic [CFG_W-1:0]     RESET_WIDTH    = 7'd64;
   localparam logic [CFG_W-1:0]     RESET_HEIGHT   = 7'd64;
   localparam logic [CHANNEL_W-1:0] RESET_CHANNELS = 3'd3;

   // Default sizes of the texture store.
   localparam int DEFAULT_MAX_WIDTH    = 64;
   localparam int DEFAULT_MAX_HEIGHT   = 64;
   localparam int DEFAULT_MAX_CHANNELS = 4;

   // Four taps (A, B, C, D) and three blended channels.
   localparam int TAP_COUNT   = 4;
   localparam int COLOR_COUNT = 3;

   // A texel index is below 127*127 and an element index below 4*127*127.
   localparam int TEXEL_W  = 2 * CFG_W;
   localparam int ELEM_W   = TEXEL_W + 2;
   localparam int WEIGHT_W = 2 * FRAC_W + 1;
   localparam int PROD_W   = WEIGHT_W + VALUE_W;
   localparam int ACC_W    = PROD_W + 1;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic             four_channels;
   } bts_cfg_type;

   typedef struct packed {
      logic               is_load;
      logic [ADDR_W-1:0]  address;
      logic [VALUE_W-1:0] value;
   } bts_load_type;

   typedef struct packed {
      bts_load_type                                      load;
      logic [TAP_COUNT-1:0][COLOR_COUNT-1:0][ELEM_W-1:0] element_index;
      logic [TAP_COUNT-1:0][WEIGHT_W-1:0]                weight;
   } bts_entry_type;

   // Clamps a 1-based position to 1..limit and returns it 0-based.
   function automatic logic [CFG_W-1:0] clamp_index(input logic [CFG_W+2:0] pos,
                                                    input logic [CFG_W-1:0] limit);
      logic [CFG_W+2:0] less;
      less = pos - {{3{1'b0}}, 7'd1};
      if (pos == '0) begin
         return '0;
      end else if (pos > {3'b000, limit}) begin
         return limit - 7'd1;
      end else begin
         return less[CFG_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/bts_bank.sv
// One copy of the texture store: one write port and one registered read port.
// Depends on bts_pkg for the element width.
`default_nettype none

module bts_bank
   import bts_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_WIDTH * DEFAULT_MAX_HEIGHT * DEFAULT_MAX_CHANNELS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               write_enable,
   input  logic [AW-1:0]      write_address,
   input  logic [VALUE_W-1:0] write_data,
   input  logic [AW-1:0]      read_address,
   output logic [VALUE_W-1:0] read_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: design/bts_front.sv
// Front end: accepts words, works out tap addresses and blend weights.
// Depends on bts_pkg; feeds bts_queue.
`default_nettype none

module bts_front
   import bts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_kind,
   input  logic [ADDR_W-1:0]         req_element_address,
   input  logic signed [VALUE_W-1:0] req_element_value,
   input  logic [COORD_W-1:0]        req_sample_u,
   input  logic [COORD_W-1:0]        req_sample_v,
   input  bts_cfg_type               cfg,
   input  logic                      queue_full,
   output logic                      push_valid,
   output bts_entry_type             push_entry
);

   logic stall;
   logic accept;

   // Stage 1: the two coordinate products.
   logic                s1_valid_ff, s1_valid_in;
   bts_load_type        s1_load_ff, s1_load_in;
   logic [23:0]         s1_px_ff, s1_px_in;
   logic signed [25:0]  s1_py_ff, s1_py_in;
   logic signed [17:0]  flipped_v;

   // Stage 2: rounded positions, clamped taps and fractions.
   logic                s2_valid_ff, s2_valid_in;
   bts_load_type        s2_load_ff, s2_load_in;
   logic [CFG_W-1:0]    s2_x1_ff, s2_x1_in, s2_x2_ff, s2_x2_in;
   logic [CFG_W-1:0]    s2_y1_ff, s2_y1_in, s2_y2_ff, s2_y2_in;
   logic [FRAC_W-1:0]   s2_fu_ff, s2_fu_in, s2_fv_ff, s2_fv_in;
   logic [24:0]         sum_x;
   logic signed [25:0]  sum_y;
   logic                row_negative;

   // Stage 3: row bases and the four weights.
   logic                              s3_valid_ff, s3_valid_in;
   bts_load_type                      s3_load_ff, s3_load_in;
   logic [CFG_W-1:0]                  s3_x1_ff, s3_x1_in, s3_x2_ff, s3_x2_in;
   logic [TEXEL_W-1:0]                s3_base1_ff, s3_base1_in, s3_base2_ff, s3_base2_in;
   logic [TAP_COUNT-1:0][WEIGHT_W-1:0] s3_weight_ff, s3_weight_in;
   logic [FRAC_W:0]                   gu, gv;
   logic [2*FRAC_W+1:0]               prod_a, prod_b, prod_c, prod_d;

   // Stage 4: element indexes, ready for the queue.
   logic               s4_valid_ff, s4_valid_in;
   bts_entry_type      s4_entry_ff, s4_entry_in;
   logic [CFG_W-1:0]   tap_col [TAP_COUNT];
   logic [TEXEL_W-1:0] tap_base [TAP_COUNT];
   logic [TEXEL_W-1:0] texel;
   logic [ELEM_W-1:0]  element;

   assign stall  = s4_valid_ff & queue_full;
   assign busy   = stall;
   assign accept = start & ~stall;

   always_comb begin
      s1_valid_in        = accept;
      s1_load_in.is_load = ~req_kind;
      s1_load_in.address = req_element_address;
      s1_load_in.value   = req_element_value;
      flipped_v          = 18'sd65536 - $signed({1'b0, req_sample_v});
      s1_px_in           = {17'b0, cfg.width} * {7'b0, req_sample_u};
      s1_py_in           = $signed({19'b0, cfg.height}) * 26'(flipped_v);
   end

   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_load_in   = s1_load_ff;
      sum_x        = {1'b0, s1_px_ff} + 25'd32768;
      sum_y        = s1_py_ff + 26'sd32768;
      row_negative = sum_y[25];
      s2_x1_in     = clamp_index({1'b0, sum_x[24:16]}, cfg.width);
      s2_x2_in     = clamp_index({1'b0, sum_x[24:16]} + 10'd1, cfg.width);
      s2_fu_in     = sum_x[FRAC_W-1:0];
      // A row position below zero puts both rows on the first one.
      if (row_negative) begin
         s2_y1_in = '0;
         s2_y2_in = '0;
         s2_fv_in = '0;
      end else begin
         s2_y1_in = clamp_index({1'b0, sum_y[24:16]}, cfg.height);
         s2_y2_in = clamp_index({1'b0, sum_y[24:16]} + 10'd1, cfg.height);
         s2_fv_in = sum_y[FRAC_W-1:0];
      end
   end

   always_comb begin
      s3_valid_in     = s2_valid_ff;
      s3_load_in      = s2_load_ff;
      s3_x1_in        = s2_x1_ff;
      s3_x2_in        = s2_x2_ff;
      s3_base1_in     = {7'b0, cfg.width} * {7'b0, s2_y1_ff};
      s3_base2_in     = {7'b0, cfg.width} * {7'b0, s2_y2_ff};
      gu              = 17'd65536 - {1'b0, s2_fu_ff};
      gv              = 17'd65536 - {1'b0, s2_fv_ff};
      prod_a          = {17'b0, gu} * {17'b0, gv};
      prod_b          = {18'b0, s2_fu_ff} * {17'b0, gv};
      prod_c          = {17'b0, gu} * {18'b0, s2_fv_ff};
      prod_d          = {18'b0, s2_fu_ff} * {18'b0, s2_fv_ff};
      s3_weight_in[0] = prod_a[WEIGHT_W-1:0];
      s3_weight_in[1] = prod_b[WEIGHT_W-1:0];
      s3_weight_in[2] = prod_c[WEIGHT_W-1:0];
      s3_weight_in[3] = prod_d[WEIGHT_W-1:0];
   end

   always_comb begin
      texel   = '0;
      element = '0;
      // Taps in order: A (x1,y1), B (x2,y1), C (x1,y2), D (x2,y2).
      tap_col[0]  = s3_x1_ff;
      tap_col[1]  = s3_x2_ff;
      tap_col[2]  = s3_x1_ff;
      tap_col[3]  = s3_x2_ff;
      tap_base[0] = s3_base1_ff;
      tap_base[1] = s3_base1_ff;
      tap_base[2] = s3_base2_ff;
      tap_base[3] = s3_base2_ff;
      s4_valid_in        = s3_valid_ff;
      s4_entry_in.load   = s3_load_ff;
      s4_entry_in.weight = s3_weight_ff;
      for (int k = 0; k < TAP_COUNT; k++) begin
         texel = tap_base[k] + {7'b0, tap_col[k]};
         if (cfg.four_channels) begin
            element = {texel, 2'b00};
         end else begin
            element = {1'b0, texel, 1'b0} + {2'b00, texel};
         end
         for (int c = 0; c < COLOR_COUNT; c++) begin
            s4_entry_in.element_index[k][c] = element + ELEM_W'(c);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_load_ff   <= s1_load_in;
         s1_px_ff     <= s1_px_in;
         s1_py_ff     <= s1_py_in;
         s2_load_ff   <= s2_load_in;
         s2_x1_ff     <= s2_x1_in;
         s2_x2_ff     <= s2_x2_in;
         s2_y1_ff     <= s2_y1_in;
         s2_y2_ff     <= s2_y2_in;
         s2_fu_ff     <= s2_fu_in;
         s2_fv_ff     <= s2_fv_in;
         s3_load_ff   <= s3_load_in;
         s3_x1_ff     <= s3_x1_in;
         s3_x2_ff     <= s3_x2_in;
         s3_base1_ff  <= s3_base1_in;
         s3_base2_ff  <= s3_base2_in;
         s3_weight_ff <= s3_weight_in;
         s4_entry_ff  <= s4_entry_in;
      end
   end

   assign push_valid = s4_valid_ff & ~queue_full;
   assign push_entry = s4_entry_ff;

endmodule

`default_nettype wire

FILE: design/bts_queue.sv
// Short queue that decouples the front end from the store and blend stages.
// Depends on bts_pkg for the entry type and depth.
`default_nettype none

module bts_queue
   import bts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  bts_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output bts_entry_type head_entry
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   bts_entry_type      slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0]   read_ptr_ff, read_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[read_ptr_ff];
   assign do_push    = push_valid & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         write_ptr_in = (write_ptr_ff == LAST_SLOT) ? '0 : write_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         read_ptr_in = (read_ptr_ff == LAST_SLOT) ? '0 : read_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         count_ff     <= '0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[write_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/bts_back.sv
// Back end: applies loads to the texture store, reads the taps and blends.
// Depends on bts_pkg and bts_bank; takes words from bts_queue.
`default_nettype none

module bts_back
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH    = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT   = DEFAULT_MAX_HEIGHT,
   parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  bts_entry_type             head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_red,
   output logic signed [VALUE_W-1:0] rsp_green,
   output logic signed [VALUE_W-1:0] rsp_blue
);

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
   localparam int SAW         = $clog2(STORE_DEPTH);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'h8000_0000);

   logic                  store_write;
   logic [SAW-1:0]        write_address;
   logic [TAP_COUNT-1:0][COLOR_COUNT-1:0][VALUE_W-1:0] bank_data;

   logic                               b1_valid_ff, b1_valid_in;
   logic [TAP_COUNT-1:0][WEIGHT_W-1:0] b1_weight_ff;

   logic                                             b2_valid_ff, b2_valid_in;
   logic [TAP_COUNT-1:0][COLOR_COUNT-1:0][PROD_W-1:0] b2_prod_ff, b2_prod_in;
   logic [VALUE_W-1:0]                               biased;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [COLOR_COUNT-1:0][VALUE_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [ACC_W-1:0]                     acc;
   logic [VALUE_W-1:0]                   rounded;

   // The back end never waits, so a word leaves the queue as soon as it shows.
   assign pop           = head_valid;
   assign store_write   = head_valid & head_entry.load.is_load &
                          ({18'b0, head_entry.load.address} < 32'(STORE_DEPTH));
   assign write_address = SAW'(head_entry.load.address);

   // Every load goes to all copies, so each tap channel has a read port of its own.
   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
      for (genvar c = 0; c < COLOR_COUNT; c++) begin : g_color
         bts_bank #(
            .DEPTH(STORE_DEPTH)
         ) u_bank (
            .clock        (clock),
            .write_enable (store_write),
            .write_address(write_address),
            .write_data   (head_entry.load.value),
            .read_address (SAW'(head_entry.element_index[k][c])),
            .read_data    (bank_data[k][c])
         );
      end
   end

   assign b1_valid_in = head_valid & ~head_entry.load.is_load;

   // Texels are blended offset by half of full scale, as unsigned numbers.
   always_comb begin
      biased      = '0;
      b2_valid_in = b1_valid_ff;
      for (int k = 0; k < TAP_COUNT; k++) begin
         for (int c = 0; c < COLOR_COUNT; c++) begin
            biased = {~bank_data[k][c][VALUE_W-1], bank_data[k][c][VALUE_W-2:0]};
            b2_prod_in[k][c] = {{VALUE_W{1'b0}}, b1_weight_ff[k]} *
                               {{WEIGHT_W{1'b0}}, biased};
         end
      end
   end

   always_comb begin
      acc          = '0;
      rounded      = '0;
      rsp_valid_in = b2_valid_ff;
      for (int c = 0; c < COLOR_COUNT; c++) begin
         acc = ROUND_HALF;
         for (int k = 0; k < TAP_COUNT; k++) begin
            acc = acc + {1'b0, b2_prod_ff[k][c]};
         end
         rounded         = acc[2*FRAC_W +: VALUE_W];
         rsp_color_in[c] = {~rounded[VALUE_W-1], rounded[VALUE_W-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         b2_valid_ff  <= b2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_weight_ff <= head_entry.weight;
      b2_prod_ff   <= b2_prod_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_color_ff[0];
   assign rsp_green = rsp_color_ff[1];
   assign rsp_blue  = rsp_color_ff[2];

endmodule

`default_nettype wire

FILE: design/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: configuration registers and wiring.
// Depends on bts_pkg, bts_front, bts_queue and bts_back.
`default_nettype none

// The sampler takes one word per cycle, loads and samples alike, and busy stays
// low in normal use because the back end drains the queue every cycle; the
// receiver cannot stall, and each RGB result shows on the rsp_ ports for one
// cycle with rsp_valid, in the order the samples came in; each sample word
// passes the front stages, the queue and the back-end registers. A load gives
// no result and is seen by every sample taken after it. The single-cycle rate
// comes from keeping twelve copies of the texture store, one read port for each
// channel of each of the four taps, all written by every load; there is no
// clearing pass after reset, and an entry must be loaded before a sample reads
// it. Write the configuration registers only while no words are in flight.
module bilinear_texture_sampler
   import bts_pkg::*;
#(
   parameter int MAX_WIDTH    = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT   = DEFAULT_MAX_HEIGHT,
   parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_kind,
   input  logic [ADDR_W-1:0]         req_element_address,
   input  logic signed [VALUE_W-1:0] req_element_value,
   input  logic [COORD_W-1:0]        req_sample_u,
   input  logic [COORD_W-1:0]        req_sample_v,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_red,
   output logic signed [VALUE_W-1:0] rsp_green,
   output logic signed [VALUE_W-1:0] rsp_blue,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]          csr_write_data
);

   localparam logic [CFG_W-1:0] WIDTH_LIMIT  = (MAX_WIDTH > 127) ? 7'd127 : 7'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] HEIGHT_LIMIT = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);
   localparam bit               FOUR_ALLOWED = (MAX_CHANNELS >= 4);

   logic [CFG_W-1:0]     image_width_ff, image_width_in;
   logic [CFG_W-1:0]     image_height_ff, image_height_in;
   logic [CHANNEL_W-1:0] channel_count_ff, channel_count_in;
   bts_cfg_type          cfg;

   logic          push_valid;
   bts_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   logic          head_valid;
   bts_entry_type head_entry;

   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      channel_count_in = channel_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_write_data;
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_write_data;
            end
            CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_write_data[CHANNEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= RESET_WIDTH;
         image_height_ff  <= RESET_HEIGHT;
         channel_count_ff <= RESET_CHANNELS;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         channel_count_ff <= channel_count_in;
      end
   end

   // Out-of-range settings act as the nearest legal value.
   always_comb begin
      if (image_width_ff == '0) begin
         cfg.width = 7'd1;
      end else if (image_width_ff > WIDTH_LIMIT) begin
         cfg.width = WIDTH_LIMIT;
      end else begin
         cfg.width = image_width_ff;
      end
      if (image_height_ff == '0) begin
         cfg.height = 7'd1;
      end else if (image_height_ff > HEIGHT_LIMIT) begin
         cfg.height = HEIGHT_LIMIT;
      end else begin
         cfg.height = image_height_ff;
      end
      cfg.four_channels = FOUR_ALLOWED && (channel_count_ff >= 3'd4);
   end

   bts_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_element_address(req_element_address),
      .req_element_value  (req_element_value),
      .req_sample_u       (req_sample_u),
      .req_sample_v       (req_sample_v),
      .cfg                (cfg),
      .queue_full         (queue_full),
      .push_valid         (push_valid),
      .push_entry         (push_entry)
   );

   bts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   bts_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule

`default_nettype wire
